// ===== src/ami4inv_pkg.sv =====
// ----------------------------------------------------------------------------
// ami4inv_pkg
// Shared types, constants and saturating helpers for the affine inverse block.
// ----------------------------------------------------------------------------
package ami4inv_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int VAL_W       = 64;
  localparam int QUEUE_DEPTH = 2;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // matrix positions, row * 4 + column
  localparam logic [3:0] M00 = 4'd0;
  localparam logic [3:0] M01 = 4'd1;
  localparam logic [3:0] M02 = 4'd2;
  localparam logic [3:0] M03 = 4'd3;
  localparam logic [3:0] M10 = 4'd4;
  localparam logic [3:0] M11 = 4'd5;
  localparam logic [3:0] M12 = 4'd6;
  localparam logic [3:0] M13 = 4'd7;
  localparam logic [3:0] M20 = 4'd8;
  localparam logic [3:0] M21 = 4'd9;
  localparam logic [3:0] M22 = 4'd10;
  localparam logic [3:0] M23 = 4'd11;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] in_r0c0;
    logic signed [DATA_WIDTH-1:0] in_r0c1;
    logic signed [DATA_WIDTH-1:0] in_r0c2;
    logic signed [DATA_WIDTH-1:0] in_r0c3;
    logic signed [DATA_WIDTH-1:0] in_r1c0;
    logic signed [DATA_WIDTH-1:0] in_r1c1;
    logic signed [DATA_WIDTH-1:0] in_r1c2;
    logic signed [DATA_WIDTH-1:0] in_r1c3;
    logic signed [DATA_WIDTH-1:0] in_r2c0;
    logic signed [DATA_WIDTH-1:0] in_r2c1;
    logic signed [DATA_WIDTH-1:0] in_r2c2;
    logic signed [DATA_WIDTH-1:0] in_r2c3;
  } in_t;

  typedef struct packed {
    logic [1:0]                   row_index;
    logic signed [DATA_WIDTH-1:0] out_c0;
    logic signed [DATA_WIDTH-1:0] out_c1;
    logic signed [DATA_WIDTH-1:0] out_c2;
    logic signed [DATA_WIDTH-1:0] out_c3;
    logic                         singular;
    logic                         last_row;
  } out_t;

  typedef struct packed {
    logic start;
    val_t a;
    val_t b;
  } op_req_t;

  typedef struct packed {
    logic done;
    val_t res;
  } op_rsp_t;

  typedef struct packed {
    logic [3:0] a;
    logic [3:0] b;
  } idx_pair_t;

  function automatic val_t sadd(input val_t a, input val_t b);
    logic signed [VAL_W:0] s;
    s = (VAL_W+1)'(a) + (VAL_W+1)'(b);
    if (s[VAL_W] != s[VAL_W-1]) begin
      return s[VAL_W] ? VAL_MIN : VAL_MAX;
    end
    return s[VAL_W-1:0];
  endfunction

  function automatic val_t ssub(input val_t a, input val_t b);
    logic signed [VAL_W:0] s;
    s = (VAL_W+1)'(a) - (VAL_W+1)'(b);
    if (s[VAL_W] != s[VAL_W-1]) begin
      return s[VAL_W] ? VAL_MIN : VAL_MAX;
    end
    return s[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] magn(input val_t a);
    return a[VAL_W-1] ? (VAL_W)'(-a) : (VAL_W)'(a);
  endfunction

  function automatic val_t sel_m(input in_t m, input logic [3:0] idx);
    val_t v;
    unique case (idx)
      M00: v = 64'(m.in_r0c0);
      M01: v = 64'(m.in_r0c1);
      M02: v = 64'(m.in_r0c2);
      M03: v = 64'(m.in_r0c3);
      M10: v = 64'(m.in_r1c0);
      M11: v = 64'(m.in_r1c1);
      M12: v = 64'(m.in_r1c2);
      M13: v = 64'(m.in_r1c3);
      M20: v = 64'(m.in_r2c0);
      M21: v = 64'(m.in_r2c1);
      M22: v = 64'(m.in_r2c2);
      M23: v = 64'(m.in_r2c3);
      default: v = '0;
    endcase
    return v;
  endfunction

  // operand pairs of the nine cofactors, two products each
  function automatic idx_pair_t cof_idx(input logic [4:0] step);
    idx_pair_t p;
    unique case (step)
      5'd0:  p = '{M11, M22};
      5'd1:  p = '{M21, M12};
      5'd2:  p = '{M21, M02};
      5'd3:  p = '{M22, M01};
      5'd4:  p = '{M01, M12};
      5'd5:  p = '{M11, M02};
      5'd6:  p = '{M20, M12};
      5'd7:  p = '{M10, M22};
      5'd8:  p = '{M00, M22};
      5'd9:  p = '{M20, M02};
      5'd10: p = '{M10, M02};
      5'd11: p = '{M00, M12};
      5'd12: p = '{M10, M21};
      5'd13: p = '{M20, M11};
      5'd14: p = '{M20, M01};
      5'd15: p = '{M00, M21};
      5'd16: p = '{M00, M11};
      5'd17: p = '{M10, M01};
      default: p = '{M00, M00};
    endcase
    return p;
  endfunction

endpackage

// ===== src/ami4inv_fmul.sv =====
// ----------------------------------------------------------------------------
// ami4inv_fmul
// Sequential fixed-point multiply: four 32x32 partial products, floor, saturate.
// ----------------------------------------------------------------------------
module ami4inv_fmul #(
  parameter int FRAC_BITS = ami4inv_pkg::FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ami4inv_pkg::op_req_t req_i,
  output ami4inv_pkg::op_rsp_t rsp_o
);

  localparam int HW = ami4inv_pkg::VAL_W / 2;
  localparam int PW = 2 * ami4inv_pkg::VAL_W;
  localparam logic [2:0] CNT_LAST = 3'd5;
  localparam logic [2:0] CNT_MULS = 3'd4;
  localparam logic [PW-1:0] FRAC_MASK = (PW'(1) << FRAC_BITS) - PW'(1);

  logic                            busy_q, done_q, neg_q;
  logic [2:0]                      cnt_q;
  logic [1:0]                      pj_q;
  logic [ami4inv_pkg::VAL_W-1:0]   am_q, bm_q;
  logic [2*HW-1:0]                 pp_q;
  logic [PW-1:0]                   acc_q;
  ami4inv_pkg::val_t               res_q;

  logic [HW-1:0]     a_part, b_part;
  logic [PW-1:0]     pp_sh, mag;
  logic              frac_nz;
  ami4inv_pkg::val_t res_d;

  always_comb begin
    a_part = cnt_q[1] ? am_q[2*HW-1:HW] : am_q[HW-1:0];
    b_part = cnt_q[0] ? bm_q[2*HW-1:HW] : bm_q[HW-1:0];
    if (pj_q == 2'b11) begin
      pp_sh = PW'(pp_q) << (2 * HW);
    end else if (pj_q != 2'b00) begin
      pp_sh = PW'(pp_q) << HW;
    end else begin
      pp_sh = PW'(pp_q);
    end
    frac_nz = |(acc_q & FRAC_MASK);
    mag     = (acc_q >> FRAC_BITS) + PW'(neg_q & frac_nz);
    if (!neg_q) begin
      res_d = (|mag[PW-1:ami4inv_pkg::VAL_W-1]) ? ami4inv_pkg::VAL_MAX
                                                : mag[ami4inv_pkg::VAL_W-1:0];
    end else if ((|mag[PW-1:ami4inv_pkg::VAL_W]) ||
                 (mag[ami4inv_pkg::VAL_W-1] && (|mag[ami4inv_pkg::VAL_W-2:0]))) begin
      res_d = ami4inv_pkg::VAL_MIN;
    end else begin
      res_d = -mag[ami4inv_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (req_i.start) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else if (cnt_q == CNT_LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && req_i.start) begin
      am_q  <= ami4inv_pkg::magn(req_i.a);
      bm_q  <= ami4inv_pkg::magn(req_i.b);
      neg_q <= req_i.a[ami4inv_pkg::VAL_W-1] ^ req_i.b[ami4inv_pkg::VAL_W-1];
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q < CNT_MULS) begin
        pp_q <= (2*HW)'(a_part) * (2*HW)'(b_part);
        pj_q <= cnt_q[1:0];
      end
      if (cnt_q != 3'd0 && cnt_q != CNT_LAST) begin
        acc_q <= acc_q + pp_sh;
      end
      if (cnt_q == CNT_LAST) begin
        res_q <= res_d;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

// ===== src/ami4inv_fdiv.sv =====
// ----------------------------------------------------------------------------
// ami4inv_fdiv
// Bit-serial restoring divide: num * 2^FRAC_BITS / den, truncated, saturated.
// ----------------------------------------------------------------------------
module ami4inv_fdiv #(
  parameter int FRAC_BITS = ami4inv_pkg::FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ami4inv_pkg::op_req_t req_i,
  output ami4inv_pkg::op_rsp_t rsp_o
);

  localparam int VW    = ami4inv_pkg::VAL_W;
  localparam int QW    = VW + FRAC_BITS;
  localparam int CNT_W = $clog2(QW + 1);

  logic               busy_q, done_q, neg_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [QW-1:0]      dvd_q;
  logic [VW:0]        rem_q;
  logic [VW-1:0]      den_q;
  ami4inv_pkg::val_t  res_q;

  logic [VW:0]        rem_sh, rem_sub;
  logic               bit_ok;
  ami4inv_pkg::val_t  res_d;

  always_comb begin
    rem_sh  = {rem_q[VW-1:0], dvd_q[QW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    bit_ok  = (rem_sh >= {1'b0, den_q});
    if (!neg_q) begin
      res_d = (|dvd_q[QW-1:VW-1]) ? ami4inv_pkg::VAL_MAX : dvd_q[VW-1:0];
    end else if ((|dvd_q[QW-1:VW]) || (dvd_q[VW-1] && (|dvd_q[VW-2:0]))) begin
      res_d = ami4inv_pkg::VAL_MIN;
    end else begin
      res_d = -dvd_q[VW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (req_i.start) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else if (cnt_q == CNT_W'(QW)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && req_i.start) begin
      neg_q <= req_i.a[VW-1] ^ req_i.b[VW-1];
      dvd_q <= QW'(ami4inv_pkg::magn(req_i.a)) << FRAC_BITS;
      den_q <= ami4inv_pkg::magn(req_i.b);
      rem_q <= '0;
    end else if (busy_q) begin
      if (cnt_q != CNT_W'(QW)) begin
        rem_q <= bit_ok ? rem_sub : rem_sh;
        dvd_q <= {dvd_q[QW-2:0], bit_ok};
      end else begin
        res_q <= res_d;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

// ===== src/ami4inv_front.sv =====
// ----------------------------------------------------------------------------
// ami4inv_front
// Input side: accepts matrices and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module ami4inv_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ami4inv_pkg::in_t  in_data_i,
  output logic              head_valid_o,
  output ami4inv_pkg::in_t  head_data_o,
  input  logic              pop_i
);

  localparam int DEPTH = ami4inv_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ami4inv_pkg::in_t  mem_q [DEPTH];
  ami4inv_pkg::in_t  head_q;
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              push, pop;

  assign in_stall_o   = (cnt_q == CNT_W'(DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_data_o  = head_q;
  assign push         = in_valid_i && !in_stall_o;
  assign pop          = pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // hold the popped matrix until the next pop
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
    if (pop) begin
      head_q <= mem_q[rd_q];
    end
  end

endmodule

// ===== src/ami4inv_back.sv =====
// ----------------------------------------------------------------------------
// ami4inv_back
// Sequencer: cofactors, determinant, singular test, divides, translation, rows.
// ----------------------------------------------------------------------------
module ami4inv_back #(
  parameter int FRAC_BITS = ami4inv_pkg::FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 head_valid_i,
  input  ami4inv_pkg::in_t     head_data_i,
  output logic                 pop_o,
  output ami4inv_pkg::op_req_t mul_req_o,
  input  ami4inv_pkg::op_rsp_t mul_rsp_i,
  output ami4inv_pkg::op_req_t div_req_o,
  input  ami4inv_pkg::op_rsp_t div_rsp_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ami4inv_pkg::out_t    out_data_o
);

  localparam int DW = ami4inv_pkg::DATA_WIDTH;
  localparam ami4inv_pkg::val_t SAT_HI = (64'sd1 <<< (DW - 1)) - 64'sd1;
  localparam ami4inv_pkg::val_t SAT_LO = ~SAT_HI;
  localparam ami4inv_pkg::val_t ONE_RAW = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [DW-1:0] ONE_SAT =
    (ONE_RAW > SAT_HI) ? SAT_HI[DW-1:0] : ONE_RAW[DW-1:0];
  localparam logic [4:0] COF_LAST = 5'd17;
  localparam logic [4:0] DET_LAST = 5'd2;
  localparam logic [1:0] COL_LAST = 2'd2;
  localparam logic [1:0] ROW_LAST = 2'd2;
  localparam logic [3:0] K_C01    = 4'd3;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_COF  = 7'b0000010,
    S_DET  = 7'b0000100,
    S_TEST = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_TRN  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_e;

  function automatic logic signed [DW-1:0] satw(input ami4inv_pkg::val_t v);
    if (v > SAT_HI) begin
      return SAT_HI[DW-1:0];
    end
    if (v < SAT_LO) begin
      return SAT_LO[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  state_e state_q, state_d;
  logic [4:0] step_q, step_d;
  logic [1:0] row_q, row_d_cnt, col_q, col_d;
  logic       wait_q, wait_d;
  logic       out_valid_q, out_valid_d;
  logic [15:0] thr_q;

  ami4inv_pkg::val_t  p_q, c01_q, det_q, t_q;
  ami4inv_pkg::val_t  adj_q [9];
  logic signed [DW-1:0] inv_q [3];
  logic               sing_q;
  ami4inv_pkg::out_t  out_q;

  ami4inv_pkg::idx_pair_t pair;
  ami4inv_pkg::val_t      det_b, mul_p;
  logic [3:0]             adj_idx, k;
  logic                   op_done, sing_now, out_load, issue;
  ami4inv_pkg::out_t      row_d;

  assign mul_p    = mul_rsp_i.res;
  assign k        = step_q[4:1];
  assign adj_idx  = 4'(row_q) * 4'd3 + 4'(col_q);
  assign sing_now = (det_q == '0) ||
                    (ami4inv_pkg::magn(det_q) < ami4inv_pkg::VAL_W'(thr_q));
  assign out_load = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);
  assign pop_o    = (state_q == S_IDLE) && head_valid_i;
  assign issue    = !wait_q;
  assign op_done  = (state_q == S_DIV) ? div_rsp_i.done : mul_rsp_i.done;

  always_comb begin
    pair = ami4inv_pkg::cof_idx(step_q);
    unique case (step_q[1:0])
      2'd0:    det_b = adj_q[0];
      2'd1:    det_b = c01_q;
      default: det_b = adj_q[6];
    endcase
    mul_req_o = '0;
    div_req_o = '0;
    unique case (state_q)
      S_COF: begin
        mul_req_o.start = issue;
        mul_req_o.a     = ami4inv_pkg::sel_m(head_data_i, pair.a);
        mul_req_o.b     = ami4inv_pkg::sel_m(head_data_i, pair.b);
      end
      S_DET: begin
        mul_req_o.start = issue;
        mul_req_o.a     = ami4inv_pkg::sel_m(head_data_i, {2'b00, step_q[1:0]});
        mul_req_o.b     = det_b;
      end
      S_DIV: begin
        div_req_o.start = issue;
        div_req_o.a     = adj_q[adj_idx];
        div_req_o.b     = det_q;
      end
      S_TRN: begin
        mul_req_o.start = issue;
        mul_req_o.a     = ami4inv_pkg::sel_m(head_data_i, {col_q, 2'b11});
        mul_req_o.b     = 64'(inv_q[col_q]);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    row_d.row_index = row_q;
    row_d.singular  = sing_q;
    row_d.last_row  = (row_q == ROW_LAST);
    if (sing_q) begin
      row_d.out_c0 = (row_q == 2'd0) ? ONE_SAT : '0;
      row_d.out_c1 = (row_q == 2'd1) ? ONE_SAT : '0;
      row_d.out_c2 = (row_q == 2'd2) ? ONE_SAT : '0;
      row_d.out_c3 = '0;
    end else begin
      row_d.out_c0 = inv_q[0];
      row_d.out_c1 = inv_q[1];
      row_d.out_c2 = inv_q[2];
      row_d.out_c3 = satw(ami4inv_pkg::ssub('0, t_q));
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    wait_d      = wait_q;
    out_valid_d = out_load || (out_valid_q && out_stall_i);
    if ((state_q == S_COF || state_q == S_DET || state_q == S_DIV ||
         state_q == S_TRN) && issue) begin
      wait_d = 1'b1;
    end else if (op_done) begin
      wait_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (head_valid_i) begin
          state_d = S_COF;
          step_d  = '0;
        end
      end
      S_COF: begin
        if (op_done) begin
          if (step_q == COF_LAST) begin
            state_d = S_DET;
            step_d  = '0;
          end else begin
            step_d = step_q + 5'd1;
          end
        end
      end
      S_DET: begin
        if (op_done) begin
          if (step_q == DET_LAST) begin
            state_d = S_TEST;
          end else begin
            step_d = step_q + 5'd1;
          end
        end
      end
      S_TEST: begin
        state_d = sing_now ? S_EMIT : S_DIV;
      end
      S_DIV: begin
        if (op_done) begin
          if (col_q == COL_LAST) begin
            state_d = S_TRN;
          end
        end
      end
      S_TRN: begin
        if (op_done) begin
          if (col_q == COL_LAST) begin
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_load) begin
          if (row_q == ROW_LAST) begin
            state_d = S_IDLE;
          end else begin
            state_d = sing_q ? S_EMIT : S_DIV;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // row and column counters
  always_comb begin
    row_d_cnt = row_q;
    col_d     = col_q;
    unique case (state_q)
      S_TEST: begin
        row_d_cnt = '0;
        col_d     = '0;
      end
      S_DIV, S_TRN: begin
        if (op_done) begin
          col_d = (col_q == COL_LAST) ? '0 : col_q + 2'd1;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          row_d_cnt = row_q + 2'd1;
          col_d     = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
      thr_q       <= 16'd1;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      row_q       <= row_d_cnt;
      col_q       <= col_d;
      wait_q      <= wait_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_COF && op_done) begin
      if (!step_q[0]) begin
        p_q <= mul_p;
      end else begin
        adj_q[k] <= ami4inv_pkg::ssub(p_q, mul_p);
        if (k == K_C01) begin
          c01_q <= ami4inv_pkg::ssub(mul_p, p_q);
        end
      end
    end
    if (state_q == S_DET && op_done) begin
      unique case (step_q[1:0])
        2'd0:    det_q <= mul_p;
        2'd1:    det_q <= ami4inv_pkg::ssub(det_q, mul_p);
        default: det_q <= ami4inv_pkg::sadd(det_q, mul_p);
      endcase
    end
    if (state_q == S_TEST) begin
      sing_q <= sing_now;
    end
    if (state_q == S_DIV && op_done) begin
      inv_q[col_q] <= satw(div_rsp_i.res);
    end
    if (state_q == S_TRN && op_done) begin
      t_q <= (col_q == 2'd0) ? mul_p : ami4inv_pkg::sadd(t_q, mul_p);
    end
    if (out_load) begin
      out_q <= row_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/affine_matrix4_inverse_top.sv =====
// Operations: one multiply and one divide unit, shared by all steps; a regular matrix
// takes 30 multiplies and 9 divides, a singular one 21 multiplies before its three rows.
// The units work on one matrix at a time; a two-entry input queue takes new matrices
// while one is at work.
// Reset: asynchronous, active low; queue and sequencer empty, threshold back to 1.
// ----------------------------------------------------------------------------
// affine_matrix4_inverse_top
// Affine 4x4 inverse in signed fixed point, three result rows per matrix.
// ----------------------------------------------------------------------------
module affine_matrix4_inverse_top #(
  parameter int FRAC_BITS = ami4inv_pkg::FRAC_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ami4inv_pkg::in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ami4inv_pkg::out_t out_data_o
);

  logic                 head_valid, pop;
  ami4inv_pkg::in_t     head_data;
  ami4inv_pkg::op_req_t mul_req, div_req;
  ami4inv_pkg::op_rsp_t mul_rsp, div_rsp;

  ami4inv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .head_valid_o (head_valid),
    .head_data_o  (head_data),
    .pop_i        (pop)
  );

  ami4inv_fmul #(.FRAC_BITS(FRAC_BITS)) u_fmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  ami4inv_fdiv #(.FRAC_BITS(FRAC_BITS)) u_fdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ami4inv_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .head_valid_i (head_valid),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .mul_req_o    (mul_req),
    .mul_rsp_i    (mul_rsp),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives matrices into the affine inverse block under random handshake idling
// and a long output hold-off, and checks all three result rows of every matrix
// against a fixed-point inverse computed here, across several threshold values.
// ----------------------------------------------------------------------------
module testbench;

  typedef logic signed [127:0] wide_t;

  class inverse_scoreboard;
    ami4inv_pkg::out_t rows_q[$];
    logic [15:0] thr;
    int          errors;
    int          rows_seen;
    int          singular_seen;

    function new();
      thr = 16'd1;
      errors = 0;
      rows_seen = 0;
      singular_seen = 0;
    endfunction

    function wide_t widen(ami4inv_pkg::val_t a);
      return $signed({{64{a[63]}}, a});
    endfunction

    function ami4inv_pkg::val_t clip64(wide_t v);
      if (v > 128'sh7FFF_FFFF_FFFF_FFFF) return ami4inv_pkg::VAL_MAX;
      if (v < -128'sh8000_0000_0000_0000) return ami4inv_pkg::VAL_MIN;
      return v[63:0];
    endfunction

    function ami4inv_pkg::val_t clip_word(ami4inv_pkg::val_t v);
      logic signed [ami4inv_pkg::DATA_WIDTH-1:0] w;
      if (v > 64'sh7FFF_FFFF) w = 32'sh7FFF_FFFF;
      else if (v < -64'sh8000_0000) w = 32'sh8000_0000;
      else w = v[ami4inv_pkg::DATA_WIDTH-1:0];
      return w;
    endfunction

    function ami4inv_pkg::val_t fx_mul(ami4inv_pkg::val_t a, ami4inv_pkg::val_t b);
      wide_t p;
      p = widen(a) * widen(b);
      return clip64(p >>> ami4inv_pkg::FRAC_BITS);
    endfunction

    function ami4inv_pkg::val_t fx_div(ami4inv_pkg::val_t num, ami4inv_pkg::val_t den);
      wide_t n;
      n = widen(num) <<< ami4inv_pkg::FRAC_BITS;
      return clip64(n / widen(den));
    endfunction

    function ami4inv_pkg::val_t fx_add(ami4inv_pkg::val_t a, ami4inv_pkg::val_t b);
      return clip64(widen(a) + widen(b));
    endfunction

    function ami4inv_pkg::val_t fx_sub(ami4inv_pkg::val_t a, ami4inv_pkg::val_t b);
      return clip64(widen(a) - widen(b));
    endfunction

    function ami4inv_pkg::val_t cofactor(ami4inv_pkg::val_t a, ami4inv_pkg::val_t b,
                                         ami4inv_pkg::val_t c, ami4inv_pkg::val_t d);
      return fx_sub(fx_mul(a, b), fx_mul(c, d));
    endfunction

    function void note(ami4inv_pkg::in_t mi);
      ami4inv_pkg::val_t m[3][4];
      ami4inv_pkg::val_t adj[3][3];
      ami4inv_pkg::val_t inv[3];
      ami4inv_pkg::val_t det;
      ami4inv_pkg::val_t t;
      logic [63:0]       mag;
      logic              sing;
      ami4inv_pkg::out_t row;
      m[0][0] = mi.in_r0c0; m[0][1] = mi.in_r0c1; m[0][2] = mi.in_r0c2; m[0][3] = mi.in_r0c3;
      m[1][0] = mi.in_r1c0; m[1][1] = mi.in_r1c1; m[1][2] = mi.in_r1c2; m[1][3] = mi.in_r1c3;
      m[2][0] = mi.in_r2c0; m[2][1] = mi.in_r2c1; m[2][2] = mi.in_r2c2; m[2][3] = mi.in_r2c3;
      adj[0][0] = cofactor(m[1][1], m[2][2], m[2][1], m[1][2]);
      adj[0][1] = cofactor(m[2][1], m[0][2], m[2][2], m[0][1]);
      adj[0][2] = cofactor(m[0][1], m[1][2], m[1][1], m[0][2]);
      adj[1][0] = cofactor(m[2][0], m[1][2], m[1][0], m[2][2]);
      adj[1][1] = cofactor(m[0][0], m[2][2], m[2][0], m[0][2]);
      adj[1][2] = cofactor(m[1][0], m[0][2], m[0][0], m[1][2]);
      adj[2][0] = cofactor(m[1][0], m[2][1], m[2][0], m[1][1]);
      adj[2][1] = cofactor(m[2][0], m[0][1], m[0][0], m[2][1]);
      adj[2][2] = cofactor(m[0][0], m[1][1], m[1][0], m[0][1]);
      det = fx_mul(m[0][0], adj[0][0]);
      det = fx_sub(det, fx_mul(m[0][1], cofactor(m[1][0], m[2][2], m[2][0], m[1][2])));
      det = fx_add(det, fx_mul(m[0][2], adj[2][0]));
      mag = det[63] ? 64'(-det) : 64'(det);
      sing = (det == 0) || (mag < {48'd0, thr});
      for (int r = 0; r < 3; r++) begin
        row.row_index = 2'(r);
        row.singular = sing;
        row.last_row = (r == 2);
        if (sing) begin
          for (int c = 0; c < 3; c++) begin
            inv[c] = (r == c) ? clip_word(64'sd1 <<< ami4inv_pkg::FRAC_BITS) : 0;
          end
          t = 0;
        end else begin
          for (int c = 0; c < 3; c++) inv[c] = clip_word(fx_div(adj[r][c], det));
          t = fx_mul(m[0][3], inv[0]);
          t = fx_add(t, fx_mul(m[1][3], inv[1]));
          t = fx_add(t, fx_mul(m[2][3], inv[2]));
          t = clip_word(fx_sub(0, t));
        end
        row.out_c0 = inv[0][ami4inv_pkg::DATA_WIDTH-1:0];
        row.out_c1 = inv[1][ami4inv_pkg::DATA_WIDTH-1:0];
        row.out_c2 = inv[2][ami4inv_pkg::DATA_WIDTH-1:0];
        row.out_c3 = t[ami4inv_pkg::DATA_WIDTH-1:0];
        rows_q.push_back(row);
      end
    endfunction

    function void check(ami4inv_pkg::out_t got);
      ami4inv_pkg::out_t want;
      if (rows_q.size() == 0) begin
        $error("unexpected result row %0d", got.row_index);
        errors++;
        return;
      end
      want = rows_q.pop_front();
      rows_seen++;
      if (got.singular) singular_seen++;
      if (got.row_index !== want.row_index) begin
        $error("row_index: expected %0d actual %0d", want.row_index, got.row_index);
        errors++;
      end
      if (got.out_c0 !== want.out_c0) begin
        $error("out_c0: expected %0d actual %0d", want.out_c0, got.out_c0);
        errors++;
      end
      if (got.out_c1 !== want.out_c1) begin
        $error("out_c1: expected %0d actual %0d", want.out_c1, got.out_c1);
        errors++;
      end
      if (got.out_c2 !== want.out_c2) begin
        $error("out_c2: expected %0d actual %0d", want.out_c2, got.out_c2);
        errors++;
      end
      if (got.out_c3 !== want.out_c3) begin
        $error("out_c3: expected %0d actual %0d", want.out_c3, got.out_c3);
        errors++;
      end
      if (got.singular !== want.singular) begin
        $error("singular: expected %0d actual %0d", want.singular, got.singular);
        errors++;
      end
      if (got.last_row !== want.last_row) begin
        $error("last_row: expected %0d actual %0d", want.last_row, got.last_row);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [15:0]       cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  ami4inv_pkg::in_t  in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  ami4inv_pkg::out_t out_data_o;

  inverse_scoreboard sb;
  bit                bursts_on;
  bit                hold_off;
  int                matrices_sent;

  affine_matrix4_inverse_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check(out_data_o);
  end

  // receiver: random stall bursts, or one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i = 1'b1;
        repeat (4000) @(negedge clk_i);
        out_stall_i = 1'b0;
        hold_off = 1'b0;
      end else if (bursts_on && $urandom_range(0, 7) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  initial begin
    #60_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic ami4inv_pkg::in_t diag_mat(int d0, int d1, int d2, int tr);
    ami4inv_pkg::in_t m;
    m = '0;
    m.in_r0c0 = d0; m.in_r1c1 = d1; m.in_r2c2 = d2;
    m.in_r0c3 = tr; m.in_r1c3 = -tr; m.in_r2c3 = tr;
    return m;
  endfunction

  function automatic int mid_val();
    return int'($urandom_range(0, 524288)) - 262144;
  endfunction

  function automatic ami4inv_pkg::in_t make_matrix();
    ami4inv_pkg::in_t m;
    int               kind;
    kind = $urandom_range(0, 9);
    if (kind >= 6 && kind <= 7) begin
      m = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      m.in_r0c0 = mid_val(); m.in_r0c1 = mid_val(); m.in_r0c2 = mid_val();
      m.in_r1c0 = mid_val(); m.in_r1c1 = mid_val(); m.in_r1c2 = mid_val();
      m.in_r2c0 = mid_val(); m.in_r2c1 = mid_val(); m.in_r2c2 = mid_val();
      m.in_r0c3 = $urandom; m.in_r1c3 = mid_val(); m.in_r2c3 = $urandom_range(0, 65536);
      if (kind == 8) begin
        m.in_r2c0 = m.in_r0c0; m.in_r2c1 = m.in_r0c1; m.in_r2c2 = m.in_r0c2;
      end else if (kind == 9) begin
        m.in_r0c0 = m.in_r0c0 >>> 6; m.in_r1c1 = m.in_r1c1 >>> 6; m.in_r2c2 = m.in_r2c2 >>> 6;
        m.in_r0c1 = m.in_r0c1 >>> 8; m.in_r1c2 = m.in_r1c2 >>> 8; m.in_r2c0 = m.in_r2c0 >>> 8;
        m.in_r0c2 = 0; m.in_r1c0 = 0; m.in_r2c1 = 0;
      end
    end
    return m;
  endfunction

  task automatic send_matrix(ami4inv_pkg::in_t m);
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 15)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i = m;
    do @(posedge clk_i); while (in_stall_o);
    sb.note(m);
    matrices_sent++;
  endtask

  task automatic send_random(int n);
    repeat (n) send_matrix(make_matrix());
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.rows_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_threshold(logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.thr = v;
  endtask

  task automatic send_directed();
    ami4inv_pkg::in_t m;
    send_matrix(diag_mat(65536, 65536, 65536, 0));
    send_matrix(diag_mat(65536, 65536, 65536, 196608));
    send_matrix(diag_mat(131072, 131072, 131072, -327680));
    send_matrix(diag_mat(0, 0, 0, 0));
    send_matrix({12{32'sh7FFF_FFFF}});
    send_matrix({12{32'sh8000_0000}});
    send_matrix(diag_mat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000));
    send_matrix(diag_mat(1, 1, 1, 5));
    send_matrix(diag_mat(4096, 4096, 4096, 65536));
    send_matrix(diag_mat(32768, 32768, 32768, 32'sh7FFF_FFFF));
    send_matrix(diag_mat(-65536, -65536, -65536, 32'sh8000_0000));
    m = '0;
    m.in_r0c1 = -65536; m.in_r1c0 = 65536; m.in_r2c2 = 65536;
    m.in_r0c3 = 655360; m.in_r1c3 = -131072; m.in_r2c3 = 1;
    send_matrix(m);
  endtask

  initial begin
    sb = new();
    bursts_on = 1'b1;
    hold_off = 1'b0;
    matrices_sent = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_directed();
    drain();
    write_threshold(16'd0);
    send_directed();
    drain();
    write_threshold(16'hFFFF);
    send_matrix(diag_mat(4096, 4096, 4096, 65536));
    send_matrix(diag_mat(65536, 65536, 65536, 0));
    send_random(10);
    drain();
    write_threshold(16'($urandom_range(0, 65535)));
    send_random(70);
    hold_off = 1'b1;
    send_random(10);
    drain();
    write_threshold(16'($urandom_range(0, 255)));
    send_random(80);
    drain();
    write_threshold(16'd1);
    bursts_on = 1'b0;
    send_random(30);
    drain();
    repeat (1100) @(posedge clk_i);

    $display("covered %0d matrices, %0d rows checked, %0d singular rows, thresholds 0..65535",
             matrices_sent, sb.rows_seen, sb.singular_seen);
    if (sb.errors == 0 && sb.rows_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== affine_matrix4_inverse_top.f =====
src/ami4inv_pkg.sv
src/ami4inv_fmul.sv
src/ami4inv_fdiv.sv
src/ami4inv_front.sv
src/ami4inv_back.sv
src/affine_matrix4_inverse_top.sv
tb/sv/testbench.sv
